@@ rtl/kce_pkg.sv @@
// shared constants, codes and interface types of the k-means cluster engine
package kce_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_DIMS     = 8;
  localparam int MAX_CLUSTERS = 16;
  localparam int COORD_W      = 16;

  localparam int PT_IDX_W  = $clog2(MAX_POINTS);
  localparam int PT_CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIM_IDX_W = $clog2(MAX_DIMS);
  localparam int DIM_CNT_W = $clog2(MAX_DIMS + 1);
  localparam int CL_IDX_W  = $clog2(MAX_CLUSTERS);
  localparam int CL_CNT_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int ITER_W    = 8;

  localparam int PT_DEPTH  = MAX_POINTS * MAX_DIMS;
  localparam int PT_A_W    = $clog2(PT_DEPTH);
  localparam int CEN_DEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int CEN_A_W   = $clog2(CEN_DEPTH);
  localparam int SUM_W     = COORD_W + PT_IDX_W + 1;
  localparam int DIST_W    = 2 * COORD_W + DIM_IDX_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam int MODE_W    = 3;
  localparam int KIND_W    = 2;
  localparam int CFG_W     = PT_CNT_W;
  localparam int CFG_IDX_W = 2;

  localparam int IN_FIELDS_W  = COORD_W + PT_IDX_W + CL_IDX_W + DIM_IDX_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CL_IDX_W + COORD_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_LOAD_PT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_CEN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RUN      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_LBL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_CEN = 3'd4;

  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LABEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COORD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = 2'd3;

  localparam logic [PT_CNT_W-1:0]  RST_POINT_COUNT     = 11'd1024;
  localparam logic [DIM_CNT_W-1:0] RST_DIMENSION_COUNT = 4'd2;
  localparam logic [CL_CNT_W-1:0]  RST_CLUSTER_COUNT   = 5'd4;
  localparam logic [ITER_W-1:0]    RST_ITERATION_COUNT = 8'd10;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_PT, OP_LOAD_CEN, OP_READ_LBL, OP_READ_CEN, OP_CLEAR,
    OP_DIST, OP_ACC, OP_UPD_RD, OP_DIV_LOAD, OP_UPD_WR, OP_DONE
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_DIST, S_DRAIN, S_ACC, S_UPD_CHK, S_UPD_RD, S_DIV_LD,
    S_DIV, S_UPD_WR, S_DONE
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [PT_IDX_W-1:0]  p;
    logic [CL_IDX_W-1:0]  c;
    logic [DIM_IDX_W-1:0] d;
    logic [CEN_A_W-1:0]   k;
    logic                 first;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic div_busy;
    logic out_free;
    logic read_pend;
  } sts_t;

endpackage

@@ rtl/kce_ram.sv @@
// generic simple dual-port ram with registered read
module kce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/kce_ctrl.sv @@
// sequencer state machine and configuration registers of the k-means engine
module kce_ctrl import kce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [MODE_W-1:0]    mode,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  sts_t                 sts,
  output cmd_t                 cmd
);

  state_t               state, state_next;
  logic [ITER_W-1:0]    it, it_next;
  logic [PT_IDX_W-1:0]  p, p_next;
  logic [CL_IDX_W-1:0]  c, c_next;
  logic [DIM_IDX_W-1:0] d, d_next;
  logic [CEN_A_W-1:0]   k, k_next;
  logic [1:0]           drain, drain_next;

  logic [PT_CNT_W-1:0]  point_count;
  logic [DIM_CNT_W-1:0] dimension_count;
  logic [CL_CNT_W-1:0]  cluster_count;
  logic [ITER_W-1:0]    iteration_count;

  logic [PT_CNT_W-1:0]  np;
  logic [DIM_CNT_W-1:0] nd;
  logic [CL_CNT_W-1:0]  nc;
  logic last_p, last_d, last_c, last_k, last_it;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      it              <= '0;
      p               <= '0;
      c               <= '0;
      d               <= '0;
      k               <= '0;
      drain           <= '0;
      point_count     <= RST_POINT_COUNT;
      dimension_count <= RST_DIMENSION_COUNT;
      cluster_count   <= RST_CLUSTER_COUNT;
      iteration_count <= RST_ITERATION_COUNT;
    end else begin
      state <= state_next;
      it    <= it_next;
      p     <= p_next;
      c     <= c_next;
      d     <= d_next;
      k     <= k_next;
      drain <= drain_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT:     point_count     <= cfg_data[PT_CNT_W-1:0];
          REG_DIMENSION_COUNT: dimension_count <= cfg_data[DIM_CNT_W-1:0];
          REG_CLUSTER_COUNT:   cluster_count   <= cfg_data[CL_CNT_W-1:0];
          REG_ITERATION_COUNT: iteration_count <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // counts saturated into their ranges
  always_comb begin
    np = point_count;
    if (point_count == '0) np = PT_CNT_W'(1);
    else if (point_count > PT_CNT_W'(MAX_POINTS)) np = PT_CNT_W'(MAX_POINTS);
    nd = dimension_count;
    if (dimension_count == '0) nd = DIM_CNT_W'(1);
    else if (dimension_count > DIM_CNT_W'(MAX_DIMS)) nd = DIM_CNT_W'(MAX_DIMS);
    nc = cluster_count;
    if (cluster_count == '0) nc = CL_CNT_W'(1);
    else if (cluster_count > CL_CNT_W'(MAX_CLUSTERS)) nc = CL_CNT_W'(MAX_CLUSTERS);
  end

  assign last_p  = ({1'b0, p} + PT_CNT_W'(1)) == np;
  assign last_d  = ({1'b0, d} + DIM_CNT_W'(1)) == nd;
  assign last_c  = ({1'b0, c} + CL_CNT_W'(1)) == nc;
  assign last_k  = k == CEN_A_W'(CEN_DEPTH - 1);
  assign last_it = ({1'b0, it} + (ITER_W + 1)'(1)) == {1'b0, iteration_count};

  always_comb begin
    state_next = state;
    it_next    = it;
    p_next     = p;
    c_next     = c;
    d_next     = d;
    k_next     = k;
    drain_next = drain;
    s_tready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.p      = p;
    cmd.c      = c;
    cmd.d      = d;
    cmd.k      = k;
    cmd.first  = d == '0;
    cmd.last   = last_d;
    case (state)
      S_IDLE: begin
        s_tready = !sts.read_pend && sts.out_free;
        if (s_tvalid && s_tready) begin
          case (mode)
            MODE_LOAD_PT:  cmd.op = OP_LOAD_PT;
            MODE_LOAD_CEN: cmd.op = OP_LOAD_CEN;
            MODE_READ_LBL: cmd.op = OP_READ_LBL;
            MODE_READ_CEN: cmd.op = OP_READ_CEN;
            MODE_RUN: begin
              it_next = '0;
              k_next  = '0;
              if (iteration_count == '0) state_next = S_DONE;
              else state_next = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        k_next = k + CEN_A_W'(1);
        if (last_k) begin
          state_next = S_DIST;
          p_next     = '0;
          c_next     = '0;
          d_next     = '0;
        end
      end
      S_DIST: begin
        cmd.op = OP_DIST;
        if (last_d) begin
          d_next = '0;
          if (last_c) begin
            c_next     = '0;
            drain_next = '0;
            state_next = S_DRAIN;
          end else begin
            c_next = c + CL_IDX_W'(1);
          end
        end else begin
          d_next = d + DIM_IDX_W'(1);
        end
      end
      S_DRAIN: begin
        drain_next = drain + 2'd1;
        if (drain == 2'd2) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (last_d) begin
          d_next = '0;
          if (last_p) begin
            c_next     = '0;
            state_next = S_UPD_CHK;
          end else begin
            p_next     = p + PT_IDX_W'(1);
            state_next = S_DIST;
          end
        end else begin
          d_next = d + DIM_IDX_W'(1);
        end
      end
      S_UPD_CHK: begin
        d_next = '0;
        if (!sts.count_zero) begin
          state_next = S_UPD_RD;
        end else if (!last_c) begin
          c_next = c + CL_IDX_W'(1);
        end else if (last_it) begin
          state_next = S_DONE;
        end else begin
          it_next    = it + ITER_W'(1);
          k_next     = '0;
          state_next = S_CLEAR;
        end
      end
      S_UPD_RD: begin
        cmd.op     = OP_UPD_RD;
        state_next = S_DIV_LD;
      end
      S_DIV_LD: begin
        cmd.op     = OP_DIV_LOAD;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) state_next = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.op = OP_UPD_WR;
        if (!last_d) begin
          d_next     = d + DIM_IDX_W'(1);
          state_next = S_UPD_RD;
        end else if (!last_c) begin
          d_next     = '0;
          c_next     = c + CL_IDX_W'(1);
          state_next = S_UPD_CHK;
        end else if (last_it) begin
          d_next     = '0;
          state_next = S_DONE;
        end else begin
          d_next     = '0;
          it_next    = it + ITER_W'(1);
          k_next     = '0;
          state_next = S_CLEAR;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op     = OP_DONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/kce_datapath.sv @@
// stores, distance pipeline, accumulators, divider and result register
module kce_datapath import kce_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  input  logic signed [COORD_W-1:0]  value,
  input  logic [PT_IDX_W-1:0]        point_index,
  input  logic [CL_IDX_W-1:0]        cluster_index,
  input  logic [DIM_IDX_W-1:0]       dim_index,
  input  logic                       out_ready,
  output sts_t                       sts,
  output logic                       out_valid,
  output logic [KIND_W-1:0]          kind,
  output logic [CL_IDX_W-1:0]        label,
  output logic signed [COORD_W-1:0]  coord
);

  function automatic logic [CEN_A_W-1:0] cen_addr(input logic [CL_IDX_W-1:0] ci,
                                                  input logic [DIM_IDX_W-1:0] di);
    return CEN_A_W'(CEN_A_W'(ci) * CEN_A_W'(MAX_DIMS) + CEN_A_W'(di));
  endfunction

  function automatic logic [PT_A_W-1:0] pt_addr(input logic [PT_IDX_W-1:0] pi,
                                                input logic [DIM_IDX_W-1:0] di);
    return PT_A_W'(PT_A_W'(pi) * PT_A_W'(MAX_DIMS) + PT_A_W'(di));
  endfunction

  logic [COORD_W-1:0]  pt_rdata, cen_rdata, cen_wdata;
  logic [CEN_A_W-1:0]  cen_raddr, cen_waddr, sum_raddr, sum_waddr;
  logic                cen_we, sum_we, lbl_we;
  logic [SUM_W-1:0]    sum_rdata, sum_wdata;
  logic [CL_IDX_W-1:0] lbl_rdata;

  // distance pipeline
  logic                 v1, f1, l1, v2, f2, l2, v3, f3, l3;
  logic [CL_IDX_W-1:0]  c1, c2, c3;
  logic [COORD_W:0]     diff, mag;
  logic [COORD_W-1:0]   a2;
  logic [2*COORD_W-1:0] sq3;
  logic [DIST_W-1:0]    acc, total, best_d;
  logic [CL_IDX_W-1:0]  best_c;

  // accumulation
  logic                acc_v;
  logic [CEN_A_W-1:0]  acc_addr;
  logic [PT_CNT_W-1:0] count [MAX_CLUSTERS];
  logic [PT_CNT_W-1:0] count_sel;
  logic [PT_CNT_W-1:0] fill;

  // divider
  logic                 div_busy, div_neg;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SUM_W-1:0]     quo;
  logic [PT_CNT_W-1:0]  rem, dvs;
  logic [PT_CNT_W:0]    rem_sh, rem_sub;
  logic [COORD_W-1:0]   q_lo, div_res;

  // read requests
  logic              pend, lbl_ok;
  logic [KIND_W-1:0] pend_kind;

  kce_ram #(.WIDTH(COORD_W), .DEPTH(PT_DEPTH)) u_point (
    .clk   (clk),
    .we    (cmd.op == OP_LOAD_PT),
    .waddr (pt_addr(point_index, dim_index)),
    .wdata (value),
    .raddr (pt_addr(cmd.p, cmd.d)),
    .rdata (pt_rdata)
  );

  assign cen_raddr = (cmd.op == OP_DIST) ? cen_addr(cmd.c, cmd.d)
                                         : cen_addr(cluster_index, dim_index);
  assign cen_we    = (cmd.op == OP_LOAD_CEN) || (cmd.op == OP_UPD_WR);
  assign cen_waddr = (cmd.op == OP_UPD_WR) ? cen_addr(cmd.c, cmd.d)
                                           : cen_addr(cluster_index, dim_index);
  assign cen_wdata = (cmd.op == OP_UPD_WR) ? div_res : value;

  kce_ram #(.WIDTH(COORD_W), .DEPTH(CEN_DEPTH)) u_centroid (
    .clk   (clk),
    .we    (cen_we),
    .waddr (cen_waddr),
    .wdata (cen_wdata),
    .raddr (cen_raddr),
    .rdata (cen_rdata)
  );

  assign sum_raddr = (cmd.op == OP_ACC) ? cen_addr(best_c, cmd.d) : cen_addr(cmd.c, cmd.d);
  assign sum_we    = (cmd.op == OP_CLEAR) || acc_v;
  assign sum_waddr = (cmd.op == OP_CLEAR) ? cmd.k : acc_addr;
  assign sum_wdata = (cmd.op == OP_CLEAR) ? '0 :
                     sum_rdata + {{(SUM_W-COORD_W){pt_rdata[COORD_W-1]}}, pt_rdata};

  kce_ram #(.WIDTH(SUM_W), .DEPTH(CEN_DEPTH)) u_sum (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign lbl_we = (cmd.op == OP_ACC) && cmd.first;

  kce_ram #(.WIDTH(CL_IDX_W), .DEPTH(MAX_POINTS)) u_label (
    .clk   (clk),
    .we    (lbl_we),
    .waddr (cmd.p),
    .wdata (best_c),
    .raddr (point_index),
    .rdata (lbl_rdata)
  );

  assign diff  = {pt_rdata[COORD_W-1], pt_rdata} - {cen_rdata[COORD_W-1], cen_rdata};
  assign mag   = diff[COORD_W] ? (~diff + (COORD_W+1)'(1)) : diff;
  assign total = (f3 ? '0 : acc) + DIST_W'(sq3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.op == OP_DIST;
      v2 <= v1;
      v3 <= v2;
    end
    f1  <= cmd.first;
    l1  <= cmd.last;
    c1  <= cmd.c;
    f2  <= f1;
    l2  <= l1;
    c2  <= c1;
    a2  <= mag[COORD_W-1:0];
    f3  <= f2;
    l3  <= l2;
    c3  <= c2;
    sq3 <= a2 * a2;
    if (v3) begin
      acc <= total;
      if (l3 && ((c3 == '0) || (total < best_d))) begin
        best_d <= total;
        best_c <= c3;
      end
    end
  end

  assign count_sel = count[cmd.c];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_v <= 1'b0;
      fill  <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) count[i] <= '0;
    end else begin
      acc_v <= cmd.op == OP_ACC;
      if (cmd.op == OP_CLEAR) begin
        for (int i = 0; i < MAX_CLUSTERS; i++) count[i] <= '0;
      end else if (lbl_we) begin
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          if (best_c == CL_IDX_W'(i)) count[i] <= count[i] + PT_CNT_W'(1);
        end
        if ({1'b0, cmd.p} >= fill) fill <= {1'b0, cmd.p} + PT_CNT_W'(1);
      end
    end
    acc_addr <= cen_addr(best_c, cmd.d);
  end

  assign rem_sh  = {rem, quo[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign q_lo    = quo[COORD_W-1:0];
  assign div_res = div_neg ? (~q_lo + COORD_W'(1)) : q_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.op == OP_DIV_LOAD) begin
      div_busy <= 1'b1;
      div_cnt  <= DIV_CNT_W'(SUM_W);
    end else if (div_busy) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
      if (div_cnt == DIV_CNT_W'(1)) div_busy <= 1'b0;
    end
    if (cmd.op == OP_DIV_LOAD) begin
      div_neg <= sum_rdata[SUM_W-1];
      quo     <= sum_rdata[SUM_W-1] ? (~sum_rdata + SUM_W'(1)) : sum_rdata;
      rem     <= '0;
      dvs     <= count_sel;
    end else if (div_busy) begin
      if (!rem_sub[PT_CNT_W]) begin
        rem <= rem_sub[PT_CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[PT_CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= (cmd.op == OP_READ_LBL) || (cmd.op == OP_READ_CEN);
      if (pend || (cmd.op == OP_DONE)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    pend_kind <= (cmd.op == OP_READ_LBL) ? KIND_LABEL : KIND_COORD;
    lbl_ok    <= {1'b0, point_index} < fill;
    if (pend) begin
      kind  <= pend_kind;
      label <= ((pend_kind == KIND_LABEL) && lbl_ok) ? lbl_rdata : '0;
      coord <= (pend_kind == KIND_COORD) ? cen_rdata : '0;
    end else if (cmd.op == OP_DONE) begin
      kind  <= KIND_RUN;
      label <= '0;
      coord <= '0;
    end
  end

  assign sts.count_zero = count_sel == '0;
  assign sts.div_busy   = div_busy;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.read_pend  = pend;

  a_div_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_LOAD) |-> !div_busy) else $error("divider loaded while busy");
  a_wr_after_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_UPD_WR) |-> !div_busy) else $error("centroid written before quotient");
  a_read_slot: assert property (@(posedge clk) disable iff (rst)
    pend |-> (!out_valid || out_ready)) else $error("read answer overwrites result");
  a_done_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DONE) |-> (!out_valid || out_ready)) else $error("run result overwrites");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= PT_CNT_W'(MAX_POINTS)) else $error("label fill beyond store");

endmodule

@@ rtl/kmeans_cluster_engine.sv @@
// top level of the k-means cluster engine
//
//  channel  direction  handshake          payload
//  s        in         s_tvalid/s_tready  tuser mode, tdata value/point/cluster/dim
//  m        out        m_tvalid/m_tready  tuser kind, tdata label/coord
//  cfg      in         cfg_we             cfg_index, cfg_data
//
// load items are written as they are accepted; a read answer passes a pending register
// and then the result register, and no request is taken while it is pending
// a run is paced by the single point and sum memory ports and the bit-serial divider;
// each pass begins with a sweep clearing all 128 sum entries
// rst is synchronous; requests stall while a result waits on m_tready
module kmeans_cluster_engine import kce_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // value, point_index, cluster_index, dim_index
  input  logic [MODE_W-1:0]      s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // label, coord
  output logic [KIND_W-1:0]      m_tuser,   // kind
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int PI_LO = COORD_W;
  localparam int CI_LO = PI_LO + PT_IDX_W;
  localparam int DI_LO = CI_LO + CL_IDX_W;

  cmd_t                      cmd;
  sts_t                      sts;
  logic [CL_IDX_W-1:0]       label;
  logic signed [COORD_W-1:0] coord;

  kce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .mode      (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  kce_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .value         (s_tdata[COORD_W-1:0]),
    .point_index   (s_tdata[CI_LO-1:PI_LO]),
    .cluster_index (s_tdata[DI_LO-1:CI_LO]),
    .dim_index     (s_tdata[DI_LO+DIM_IDX_W-1:DI_LO]),
    .out_ready     (m_tready),
    .sts           (sts),
    .out_valid     (m_tvalid),
    .kind          (m_tuser),
    .label         (label),
    .coord         (coord)
  );

  assign m_tdata = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, coord, label};

endmodule

@@ tb/sv/kmeans_cluster_engine_test.sv @@
// self-checking testbench for the k-means cluster engine: random streams, predictor, checks
`timescale 1ns / 100ps

module kmeans_cluster_engine_test;
  import kce_pkg::*;

  localparam int LIMIT = 20000000;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] value;
    logic [PT_IDX_W-1:0]       pi;
    logic [CL_IDX_W-1:0]       ci;
    logic [DIM_IDX_W-1:0]      di;
  } request_t;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [CL_IDX_W-1:0] label;
    logic [COORD_W-1:0]  coord;
  } answer_t;

  logic                  clk, rst;
  logic                  s_tvalid, s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [MODE_W-1:0]     s_tuser;
  logic                  m_tvalid, m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  kmeans_cluster_engine DUT (.*);

  request_t pending_q[$];
  answer_t  answer_q[$];

  // predictor state
  longint   pt_mem[PT_DEPTH];
  longint   cen_mem[CEN_DEPTH];
  logic [CL_IDX_W-1:0] lbl_mem[MAX_POINTS];
  int       pc_reg, dc_reg, cc_reg, it_reg;

  // which entries the stimulus has written
  bit       pt_written[PT_DEPTH];
  bit       cen_written[CEN_DEPTH];

  int  errors, cycles, runs_done, labels_read, coords_read, answers_seen;
  int  in_gap, out_gap;
  bit  calm;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic lloyd_pass(input int np, input int nd, input int nc);
    longint sums[CEN_DEPTH];
    int     cnt[MAX_CLUSTERS];
    longint unsigned dsq, bestd;
    longint df;
    int     best;
    foreach (sums[i]) sums[i] = 0;
    foreach (cnt[i]) cnt[i] = 0;
    for (int p = 0; p < np; p++) begin
      best = 0;
      bestd = 0;
      for (int c = 0; c < nc; c++) begin
        dsq = 0;
        for (int d = 0; d < nd; d++) begin
          df = pt_mem[p*MAX_DIMS+d] - cen_mem[c*MAX_DIMS+d];
          dsq += longint'(df * df);
        end
        if (c == 0 || dsq < bestd) begin
          bestd = dsq;
          best = c;
        end
      end
      lbl_mem[p] = best;
      cnt[best]++;
      for (int d = 0; d < nd; d++) sums[best*MAX_DIMS+d] += pt_mem[p*MAX_DIMS+d];
    end
    for (int c = 0; c < nc; c++)
      if (cnt[c] != 0)
        for (int d = 0; d < nd; d++)
          cen_mem[c*MAX_DIMS+d] = sums[c*MAX_DIMS+d] / longint'(cnt[c]);
  endtask

  task automatic predict_request(input request_t r);
    answer_t a;
    a = '{kind: KIND_RUN, label: '0, coord: '0};
    case (r.mode)
      MODE_LOAD_PT:  pt_mem[r.pi*MAX_DIMS+r.di] = r.value;
      MODE_LOAD_CEN: cen_mem[r.ci*MAX_DIMS+r.di] = r.value;
      MODE_RUN: begin
        for (int i = 0; i < it_reg; i++)
          lloyd_pass(clampi(pc_reg, 1, MAX_POINTS), clampi(dc_reg, 1, MAX_DIMS),
                     clampi(cc_reg, 1, MAX_CLUSTERS));
        answer_q.push_back(a);
      end
      MODE_READ_LBL: begin
        a.kind = KIND_LABEL;
        a.label = lbl_mem[r.pi];
        answer_q.push_back(a);
      end
      MODE_READ_CEN: begin
        a.kind = KIND_COORD;
        a.coord = cen_mem[r.ci*MAX_DIMS+r.di][COORD_W-1:0];
        answer_q.push_back(a);
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        request_t r;
        r = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= r.mode;
        s_tdata <= IN_DATA_W'({r.di, r.ci, r.pi, r.value});
        in_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // answer side: backpressure, prediction on accepted requests, checking
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tready && $urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
      if (s_tvalid && s_tready) begin
        request_t r;
        r.mode  = s_tuser;
        r.value = s_tdata[COORD_W-1:0];
        r.pi    = s_tdata[COORD_W +: PT_IDX_W];
        r.ci    = s_tdata[COORD_W+PT_IDX_W +: CL_IDX_W];
        r.di    = s_tdata[COORD_W+PT_IDX_W+CL_IDX_W +: DIM_IDX_W];
        predict_request(r);
      end
      if (m_tvalid && m_tready) begin
        answer_t e, g;
        g.kind  = m_tuser;
        g.label = m_tdata[CL_IDX_W-1:0];
        g.coord = m_tdata[CL_IDX_W +: COORD_W];
        answers_seen++;
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected answer kind %0d label %0d coord %0d",
                     g.kind, g.label, $signed(g.coord));
        end else begin
          e = answer_q.pop_front();
          case (e.kind)
            KIND_RUN:   runs_done++;
            KIND_LABEL: labels_read++;
            default:    coords_read++;
          endcase
          if (g.kind !== e.kind || g.label !== e.label || g.coord !== e.coord) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at cycle %0d: expected kind %0d label %0d coord %0d, got kind %0d label %0d coord %0d",
                       cycles, e.kind, e.label, $signed(e.coord),
                       g.kind, g.label, $signed(g.coord));
          end
        end
      end
    end
  end

  task automatic push(input logic [MODE_W-1:0] mode, input int value,
                      input int pi, input int ci, input int di);
    request_t r;
    r.mode = mode;
    r.value = value[COORD_W-1:0];
    r.pi = pi;
    r.ci = ci;
    r.di = di;
    if (mode == MODE_LOAD_PT) pt_written[r.pi*MAX_DIMS+r.di] = 1'b1;
    if (mode == MODE_LOAD_CEN) cen_written[r.ci*MAX_DIMS+r.di] = 1'b1;
    pending_q.push_back(r);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_tvalid || answer_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POINT_COUNT:     pc_reg = val & 'h7FF;
      REG_DIMENSION_COUNT: dc_reg = val & 'hF;
      REG_CLUSTER_COUNT:   cc_reg = val & 'h1F;
      default:             it_reg = val & 'hFF;
    endcase
  endtask

  task automatic configure(input int np, input int nd, input int nc, input int it);
    drain();
    set_reg(REG_POINT_COUNT, np);
    set_reg(REG_DIMENSION_COUNT, nd);
    set_reg(REG_CLUSTER_COUNT, nc);
    set_reg(REG_ITERATION_COUNT, it);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  // fill every entry a run will read, then a random mix
  task automatic random_phase(input int items, input int run_pct);
    int np, nd, nc, r, ci, di;
    np = clampi(pc_reg, 1, MAX_POINTS);
    nd = clampi(dc_reg, 1, MAX_DIMS);
    nc = clampi(cc_reg, 1, MAX_CLUSTERS);
    for (int p = 0; p < np; p++)
      for (int d = 0; d < nd; d++)
        if (!pt_written[p*MAX_DIMS+d]) push(MODE_LOAD_PT, $urandom, p, 0, d);
    for (int c = 0; c < nc; c++)
      for (int d = 0; d < nd; d++)
        if (!cen_written[c*MAX_DIMS+d]) push(MODE_LOAD_CEN, $urandom, 0, c, d);
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < run_pct) push(MODE_RUN, $urandom, $urandom, $urandom, $urandom);
      else if (r < 35) begin
        if ($urandom_range(0, 1)) push(MODE_LOAD_PT, $urandom, $urandom, $urandom,
                                       $urandom);
        else push(MODE_LOAD_PT, $urandom, $urandom_range(0, np-1), $urandom,
                  $urandom_range(0, nd-1));
      end else if (r < 50) push(MODE_LOAD_CEN, $urandom, $urandom,
                                $urandom_range(0, nc-1), $urandom_range(0, nd-1));
      else if (r < 70) push(MODE_READ_LBL, $urandom, $urandom, $urandom, $urandom);
      else if (r < 94) begin
        ci = $urandom_range(0, MAX_CLUSTERS-1);
        di = $urandom_range(0, MAX_DIMS-1);
        if (!cen_written[ci*MAX_DIMS+di]) begin
          ci = 0;
          di = 0;
        end
        push(MODE_READ_CEN, $urandom, $urandom, ci, di);
      end else push($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (pt_mem[i]) pt_mem[i] = 0;
    foreach (cen_mem[i]) cen_mem[i] = 0;
    foreach (lbl_mem[i]) lbl_mem[i] = '0;
    pc_reg = RST_POINT_COUNT;
    dc_reg = RST_DIMENSION_COUNT;
    cc_reg = RST_CLUSTER_COUNT;
    it_reg = RST_ITERATION_COUNT;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: coordinate extremes, tied centroids, an empty cluster, far indexes
    push(MODE_READ_LBL, 0, MAX_POINTS-1, 0, 0);
    configure(6, 2, 3, 4);
    for (int p = 0; p < 6; p++) begin
      push(MODE_LOAD_PT, p < 3 ? -32768 + p : 32767 - p, p, 0, 0);
      push(MODE_LOAD_PT, p[0] ? 32767 : -32768, p, 0, 1);
    end
    push(MODE_LOAD_CEN, 0, 0, 0, 0);
    push(MODE_LOAD_CEN, 0, 0, 0, 1);
    push(MODE_LOAD_CEN, 0, 0, 1, 0);
    push(MODE_LOAD_CEN, 0, 0, 1, 1);
    push(MODE_LOAD_CEN, 32767, 0, 2, 0);
    push(MODE_LOAD_CEN, -32768, 0, 2, 1);
    push(MODE_LOAD_CEN, -32768, 0, MAX_CLUSTERS-1, MAX_DIMS-1);
    push(MODE_LOAD_PT, 32767, MAX_POINTS-1, 0, MAX_DIMS-1);
    push(5, 1, 1, 1, 1);
    push(7, -1, MAX_POINTS-1, MAX_CLUSTERS-1, MAX_DIMS-1);
    push(MODE_READ_CEN, 0, 0, MAX_CLUSTERS-1, MAX_DIMS-1);
    push(MODE_RUN, 0, 0, 0, 0);
    for (int p = 0; p < 6; p++) push(MODE_READ_LBL, 0, p, 0, 0);
    for (int c = 0; c < 3; c++) push(MODE_READ_CEN, 0, 0, c, 1);
    push(MODE_READ_LBL, 0, MAX_POINTS-1, 0, 0);
    random_phase(40, 8);

    // register extremes, cheap combinations only
    configure(2, 1, 2, 255);
    random_phase(20, 8);
    configure(20, MAX_DIMS, MAX_CLUSTERS, 3);
    random_phase(30, 8);
    configure(0, 15, 31, 0);
    random_phase(20, 10);
    configure(60, 0, 0, 2);
    random_phase(20, 4);
    repeat (6) begin
      configure($urandom_range(1, 40), $urandom_range(1, MAX_DIMS),
                $urandom_range(1, MAX_CLUSTERS), $urandom_range(1, 8));
      random_phase(50, 8);
    end
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d runs, %0d label reads and %0d centroid reads over %0d settings",
             runs_done, labels_read, coords_read, 11);
    $display("%0d answers checked, %0d mismatches, %0d cycles", answers_seen, errors, cycles);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
